### rtl/fdmf_pkg.sv
// fdmf_pkg: shared types and constants of the frequency domain mask filter
// request payloads, mode codes, register indexes, fixed widths
// no dependencies
`default_nettype none

package fdmf_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COORD_W      = 10;
  localparam int MODE_W       = 2;
  localparam int CUTOFF_W     = 9;
  localparam int ORDER_W      = 7;
  localparam int FRAME_W      = 11;
  localparam int D0SQ_W       = 2 * CUTOFF_W;
  localparam int D2_W         = 2 * COORD_W + 1;
  localparam int Q16_W        = 32;
  localparam int Q16_FRAC     = 16;
  localparam int PROD_W       = 2 * Q16_W;
  localparam int ORDER_STAGES = 2 ** ORDER_W - 1;
  localparam int REG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 11;

  localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(32'h0001_0000);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDEAL_LP = 2'd0,
    MODE_IDEAL_HP = 2'd1,
    MODE_BW_LP    = 2'd2,
    MODE_BW_HP    = 2'd3
  } mode_t;

  localparam logic [REG_INDEX_W-1:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_CUTOFF_RADIUS = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_FILTER_ORDER  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_COLUMNS = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_ROWS    = 3'd4;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 9'd10;
  localparam logic [ORDER_W-1:0]  ORDER_RESET  = 7'd1;
  localparam logic [FRAME_W-1:0]  FRAME_RESET  = 11'd1024;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] bin_real;
    logic signed [SAMPLE_WIDTH-1:0] bin_imag;
    logic [COORD_W-1:0]             bin_row;
    logic [COORD_W-1:0]             bin_column;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_real;
    logic signed [SAMPLE_WIDTH-1:0] out_imag;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] re;
    logic [SAMPLE_WIDTH-1:0] im;
  } sample_pair_t;

  // fixed: gain already known (zero or unity); sat: ratio or power saturated
  typedef struct packed {
    logic fixed;
    logic one;
    logic sat;
  } gain_sel_t;

endpackage

`default_nettype wire

### rtl/fdmf_ratio.sv
// fdmf_ratio: distance from centre, squared distance, classification and
// pipelined restoring division for the Q16.16 distance ratio
// depends on fdmf_pkg
`default_nettype none

module fdmf_ratio import fdmf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  in_item_t            in_item,
  input  mode_t               mode,
  input  logic [D0SQ_W-1:0]   d0sq,
  input  logic [COORD_W-1:0]  cx,
  input  logic [COORD_W-1:0]  cy,
  output logic                out_valid,
  output sample_pair_t        out_samples,
  output gain_sel_t           out_sel,
  output logic [Q16_W-1:0]    out_ratio
);

  localparam int STEPS = Q16_W;

  logic               v0, v1;
  sample_pair_t       s0, s1;
  logic [COORD_W-1:0] du, dv;
  logic [D2_W-1:0]    d2;

  logic                v   [0:STEPS];
  sample_pair_t        s   [0:STEPS];
  gain_sel_t           sel [0:STEPS];
  logic [D0SQ_W-1:0]   rem [0:STEPS];
  logic [Q16_W-1:0]    wrk [0:STEPS];

  logic [COORD_W-1:0] du_next, dv_next;
  logic               in_radius;
  logic               ideal;

  always_comb begin
    du_next = (in_item.bin_column >= cx) ? in_item.bin_column - cx : cx - in_item.bin_column;
    dv_next = (in_item.bin_row >= cy) ? in_item.bin_row - cy : cy - in_item.bin_row;
    in_radius = {{(D2_W-D0SQ_W){1'b0}}, d0sq} > d2;
    ideal   = (mode == MODE_IDEAL_LP) || (mode == MODE_IDEAL_HP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      v0   <= in_valid;
      v1   <= v0;
      v[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= '{re: in_item.bin_real, im: in_item.bin_imag};
      du <= du_next;
      dv <= dv_next;
      s1 <= s0;
      d2 <= {{(D2_W-COORD_W){1'b0}}, du} * {{(D2_W-COORD_W){1'b0}}, du} +
            {{(D2_W-COORD_W){1'b0}}, dv} * {{(D2_W-COORD_W){1'b0}}, dv};
      s[0]         <= s1;
      sel[0].fixed <= ideal || ((mode == MODE_BW_HP) && (d2 == '0));
      sel[0].one   <= ideal && ((mode == MODE_IDEAL_LP) ? in_radius : !in_radius);
      sel[0].sat   <= (d0sq == '0) ||
                      ({{(D0SQ_W+Q16_FRAC-D2_W){1'b0}}, d2} >= {d0sq, {Q16_FRAC{1'b0}}});
      rem[0]       <= D0SQ_W'(d2[D2_W-1:Q16_FRAC]);
      wrk[0]       <= {d2[Q16_FRAC-1:0], {(Q16_W-Q16_FRAC){1'b0}}};
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_div
    logic [D0SQ_W:0] rem_sh;
    logic            ge;
    always_comb begin
      rem_sh = {rem[j], wrk[j][Q16_W-1]};
      ge     = rem_sh >= {1'b0, d0sq};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s[j+1]   <= s[j];
        sel[j+1] <= sel[j];
        rem[j+1] <= ge ? D0SQ_W'(rem_sh - {1'b0, d0sq}) : D0SQ_W'(rem_sh);
        wrk[j+1] <= {wrk[j][Q16_W-2:0], ge};
      end
    end
  end

  assign out_valid   = v[STEPS];
  assign out_samples = s[STEPS];
  assign out_sel     = sel[STEPS];
  assign out_ratio   = wrk[STEPS];

endmodule

`default_nettype wire

### rtl/fdmf_power.sv
// fdmf_power: chain of truncating Q16.16 multiplications forming r^n,
// one multiplier per stage, saturation carried along
// depends on fdmf_pkg
`default_nettype none

module fdmf_power import fdmf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  sample_pair_t       in_samples,
  input  gain_sel_t          in_sel,
  input  logic [Q16_W-1:0]   in_ratio,
  input  logic [ORDER_W-1:0] order,
  output logic               out_valid,
  output sample_pair_t       out_samples,
  output gain_sel_t          out_sel,
  output logic [Q16_W-1:0]   out_power
);

  logic             v   [0:ORDER_STAGES];
  sample_pair_t     s   [0:ORDER_STAGES];
  gain_sel_t        sel [0:ORDER_STAGES];
  logic [Q16_W-1:0] p   [0:ORDER_STAGES];
  logic [Q16_W-1:0] r   [0:ORDER_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // order zero gives unity even for a saturated ratio
  always_ff @(posedge clk) begin
    if (en) begin
      s[0]       <= in_samples;
      sel[0]     <= '{fixed: in_sel.fixed, one: in_sel.one,
                      sat: in_sel.sat && (order != '0)};
      p[0]       <= Q16_ONE;
      r[0]       <= in_ratio;
    end
  end

  for (genvar k = 0; k < ORDER_STAGES; k++) begin : g_mul
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-Q16_FRAC-1:0] t;
    logic                       active;
    gain_sel_t                  sel_next;
    logic [Q16_W-1:0]           p_next;
    always_comb begin
      prod     = {{Q16_W{1'b0}}, p[k]} * {{Q16_W{1'b0}}, r[k]};
      t        = prod[PROD_W-1:Q16_FRAC];
      active   = (ORDER_W'(k) < order) && !sel[k].sat;
      sel_next = sel[k];
      p_next   = p[k];
      if (active) begin
        if (t[PROD_W-Q16_FRAC-1:Q16_W] != '0) begin
          sel_next.sat = 1'b1;
        end else begin
          p_next = t[Q16_W-1:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s[k+1]       <= s[k];
        r[k+1]       <= r[k];
        sel[k+1]     <= sel_next;
        p[k+1]       <= p_next;
      end
    end
  end

  assign out_valid   = v[ORDER_STAGES];
  assign out_samples = s[ORDER_STAGES];
  assign out_sel     = sel[ORDER_STAGES];
  assign out_power   = p[ORDER_STAGES];

endmodule

`default_nettype wire

### rtl/fdmf_gain.sv
// fdmf_gain: butterworth gain p/(1+p) or 1/(1+p) by pipelined restoring
// division, one quotient bit per stage, fixed gains passed alongside
// depends on fdmf_pkg
`default_nettype none

module fdmf_gain import fdmf_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  sample_pair_t                in_samples,
  input  gain_sel_t                   in_sel,
  input  logic [Q16_W-1:0]            in_power,
  input  mode_t                       mode,
  output logic                        out_valid,
  output sample_pair_t                out_samples,
  output logic [GAIN_FRACTION_BITS:0] out_gain
);

  localparam int F     = GAIN_FRACTION_BITS;
  localparam int STEPS = F + 1;
  localparam int DEN_W = Q16_W + 1;

  logic             v     [0:STEPS];
  sample_pair_t     s     [0:STEPS];
  logic             fixed [0:STEPS];
  logic             one   [0:STEPS];
  logic [DEN_W-1:0] den   [0:STEPS];
  logic [DEN_W-1:0] rem   [0:STEPS];
  logic [F:0]       wrk   [0:STEPS];

  logic lp;

  assign lp = (mode == MODE_BW_LP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // dividend is 2^(F+16) for low-pass and p*2^F for high-pass
  always_ff @(posedge clk) begin
    if (en) begin
      s[0]     <= in_samples;
      fixed[0] <= in_sel.fixed || in_sel.sat;
      one[0]   <= in_sel.fixed ? in_sel.one : (mode == MODE_BW_HP);
      den[0]   <= {1'b0, Q16_ONE} + {1'b0, in_power};
      rem[0]   <= lp ? DEN_W'({1'b0, Q16_ONE} >> 1) : DEN_W'(in_power[Q16_W-1:1]);
      wrk[0]   <= lp ? '0 : {in_power[0], {F{1'b0}}};
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_div
    logic [DEN_W:0] rem_sh;
    logic           ge;
    always_comb begin
      rem_sh = {rem[j], wrk[j][F]};
      ge     = rem_sh >= {1'b0, den[j]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s[j+1]     <= s[j];
        fixed[j+1] <= fixed[j];
        one[j+1]   <= one[j];
        den[j+1]   <= den[j];
        rem[j+1]   <= ge ? DEN_W'(rem_sh - {1'b0, den[j]}) : DEN_W'(rem_sh);
        wrk[j+1]   <= {wrk[j][F-1:0], ge};
      end
    end
  end

  assign out_valid   = v[STEPS];
  assign out_samples = s[STEPS];
  assign out_gain    = fixed[STEPS] ? (one[STEPS] ? {1'b1, {F{1'b0}}} : '0) : wrk[STEPS];

endmodule

`default_nettype wire

### rtl/fdmf_scale.sv
// fdmf_scale: sign-magnitude scaling of both bin parts by the gain,
// truncating toward zero, three stages
// depends on fdmf_pkg
`default_nettype none

module fdmf_scale import fdmf_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  sample_pair_t                in_samples,
  input  logic [GAIN_FRACTION_BITS:0] in_gain,
  output logic                        out_valid,
  output out_item_t                   out_item
);

  localparam int F  = GAIN_FRACTION_BITS;
  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + F + 1;

  logic          v0, v1, v2;
  logic          neg_re0, neg_im0, neg_re1, neg_im1;
  logic [SW-1:0] m_re, m_im;
  logic [F:0]    g;
  logic [PW-1:0] prod_re, prod_im;
  logic [SW-1:0] res_re, res_im;

  always_comb begin
    res_re = prod_re[F+SW-1:F];
    res_im = prod_im[F+SW-1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // the most negative value keeps its bit pattern as magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      neg_re0  <= in_samples.re[SW-1];
      neg_im0  <= in_samples.im[SW-1];
      m_re     <= in_samples.re[SW-1] ? SW'(-in_samples.re) : in_samples.re;
      m_im     <= in_samples.im[SW-1] ? SW'(-in_samples.im) : in_samples.im;
      g        <= in_gain;
      neg_re1  <= neg_re0;
      neg_im1  <= neg_im0;
      prod_re  <= {{(F+1){1'b0}}, m_re} * {{SW{1'b0}}, g};
      prod_im  <= {{(F+1){1'b0}}, m_im} * {{SW{1'b0}}, g};
      out_item.out_real <= neg_re1 ? SW'(-res_re) : res_re;
      out_item.out_imag <= neg_im1 ? SW'(-res_im) : res_im;
    end
  end

  assign out_valid = v2;

endmodule

`default_nettype wire

### rtl/frequency_domain_mask_filter.sv
// frequency_domain_mask_filter: top level, configuration registers,
// ratio, power, gain and scale pipelines and a two-entry result buffer
// depends on fdmf_pkg, fdmf_ratio, fdmf_power, fdmf_gain, fdmf_scale
//
//   channel   | signals                                   | direction
//   bin       | bin_valid, bin_ready, bin                 | in
//   result    | result_valid, result_ready, result        | out
//   config    | write_enable, register_index, write_data  | in
//
// one request per cycle while the result buffer is not full; the deepest section
// is the 127-stage power multiplier chain
// reset clears all valid bits and loads register defaults; no clearing pass
// the whole pipeline halts only when both result buffer entries are full;
// bin_ready is the inverse of that condition, decoded from the registered entry count
`default_nettype none

module frequency_domain_mask_filter import fdmf_pkg::*; #(
  parameter int MAX_DIMENSION      = 1024,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   bin_valid,
  output logic                   bin_ready,
  input  in_item_t               bin,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_item_t              result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [CFG_DATA_W-1:0]  write_data
);

  localparam int F = GAIN_FRACTION_BITS;

  mode_t              filter_mode;
  logic [CUTOFF_W-1:0] cutoff_radius;
  logic [ORDER_W-1:0]  filter_order;
  logic [FRAME_W-1:0]  frame_columns, frame_rows;
  logic [D0SQ_W-1:0]   d0sq;
  logic [FRAME_W-1:0]  cols_clamped, rows_clamped;
  logic [COORD_W-1:0]  cx, cy;

  logic en;

  logic             rt_valid;
  sample_pair_t     rt_samples;
  gain_sel_t        rt_sel;
  logic [Q16_W-1:0] rt_ratio;

  logic             pw_valid;
  sample_pair_t     pw_samples;
  gain_sel_t        pw_sel;
  logic [Q16_W-1:0] pw_power;

  logic         gn_valid;
  sample_pair_t gn_samples;
  logic [F:0]   gn_gain;

  logic      sc_valid;
  out_item_t sc_item;

  out_item_t  head, tail;
  logic [1:0] count, count_next;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= MODE_BW_LP;
      cutoff_radius <= CUTOFF_RESET;
      filter_order  <= ORDER_RESET;
      frame_columns <= FRAME_RESET;
      frame_rows    <= FRAME_RESET;
    end else if (write_enable) begin
      case (register_index)
        REG_FILTER_MODE:   filter_mode   <= mode_t'(write_data[MODE_W-1:0]);
        REG_CUTOFF_RADIUS: cutoff_radius <= write_data[CUTOFF_W-1:0];
        REG_FILTER_ORDER:  filter_order  <= write_data[ORDER_W-1:0];
        REG_FRAME_COLUMNS: frame_columns <= write_data[FRAME_W-1:0];
        REG_FRAME_ROWS:    frame_rows    <= write_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d0sq <= {{CUTOFF_W{1'b0}}, cutoff_radius} * {{CUTOFF_W{1'b0}}, cutoff_radius};
  end

  always_comb begin
    cols_clamped = (32'(frame_columns) > MAX_DIMENSION) ? FRAME_W'(MAX_DIMENSION) : frame_columns;
    rows_clamped = (32'(frame_rows) > MAX_DIMENSION) ? FRAME_W'(MAX_DIMENSION) : frame_rows;
    cx = cols_clamped[FRAME_W-1:1];
    cy = rows_clamped[FRAME_W-1:1];
  end

  assign en        = (count != 2'd2);
  assign bin_ready = en;

  fdmf_ratio u_ratio (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (bin_valid && en),
    .in_item     (bin),
    .mode        (filter_mode),
    .d0sq        (d0sq),
    .cx          (cx),
    .cy          (cy),
    .out_valid   (rt_valid),
    .out_samples (rt_samples),
    .out_sel     (rt_sel),
    .out_ratio   (rt_ratio)
  );

  fdmf_power u_power (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (rt_valid),
    .in_samples  (rt_samples),
    .in_sel      (rt_sel),
    .in_ratio    (rt_ratio),
    .order       (filter_order),
    .out_valid   (pw_valid),
    .out_samples (pw_samples),
    .out_sel     (pw_sel),
    .out_power   (pw_power)
  );

  fdmf_gain #(.GAIN_FRACTION_BITS(F)) u_gain (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (pw_valid),
    .in_samples  (pw_samples),
    .in_sel      (pw_sel),
    .in_power    (pw_power),
    .mode        (filter_mode),
    .out_valid   (gn_valid),
    .out_samples (gn_samples),
    .out_gain    (gn_gain)
  );

  fdmf_scale #(.GAIN_FRACTION_BITS(F)) u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (gn_valid),
    .in_samples (gn_samples),
    .in_gain    (gn_gain),
    .out_valid  (sc_valid),
    .out_item   (sc_item)
  );

  assign push = en && sc_valid;
  assign pop  = result_valid && result_ready;

  always_comb begin
    count_next = count;
    case (count)
      2'd0: if (push) count_next = 2'd1;
      2'd1: begin
        if (push && !pop) count_next = 2'd2;
        else if (!push && pop) count_next = 2'd0;
      end
      2'd2: if (pop) count_next = 2'd1;
      default: count_next = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) head <= sc_item;
      2'd1: begin
        if (push && pop) head <= sc_item;
        else if (push) tail <= sc_item;
      end
      2'd2: if (pop) head <= tail;
      default: ;
    endcase
  end

  assign result_valid = (count != 2'd0);
  assign result       = head;

endmodule

`default_nettype wire

### rtl/fdmf_checker.sv
// fdmf_assertions: port-level checks of the mask filter handshakes
// bound to frequency_domain_mask_filter; depends on fdmf_pkg
`default_nettype none

module fdmf_assertions import fdmf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      bin_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && bin_ready))
    else $error("results or stall present after reset");

  a_ready_only_when_buffered: assert property (@(posedge clk) disable iff (rst)
    !bin_ready |-> result_valid)
    else $error("input stalled with no result pending");

  a_ready_back_after_take: assert property (@(posedge clk) disable iff (rst)
    (!bin_ready && result_ready) |=> bin_ready)
    else $error("input still stalled after a result was taken");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed or dropped");

endmodule

bind frequency_domain_mask_filter fdmf_assertions u_fdmf_assertions (
  .clk          (clk),
  .rst          (rst),
  .bin_ready    (bin_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

### tb/sv/fdmf_checker.sv
// fdmf_checker: predicts the scaled bin for each accepted request and compares
// it with each accepted result; tracks register writes. depends on fdmf_pkg
`timescale 1ns / 1ps

module fdmf_checker import fdmf_pkg::*; #(
  parameter int MAX_DIMENSION      = 1024,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   bin_valid,
  input  logic                   bin_ready,
  input  in_item_t               bin,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  out_item_t              result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  mode_t               mode_q;
  logic [CUTOFF_W-1:0] cutoff_q;
  logic [ORDER_W-1:0]  order_q;
  logic [FRAME_W-1:0]  cols_q;
  logic [FRAME_W-1:0]  rows_q;
  out_item_t           scaled_bins[$];

  function automatic logic [63:0] radial_gain(logic [63:0] d2);
    logic [63:0] one_g, d0sq, ratio, pw;
    logic        sat;
    one_g = 64'd1 << GAIN_FRACTION_BITS;
    d0sq  = 64'(cutoff_q) * 64'(cutoff_q);
    sat   = 1'b0;
    if (mode_q == MODE_IDEAL_LP) return (d2 < d0sq) ? one_g : 64'd0;
    if (mode_q == MODE_IDEAL_HP) return (d2 < d0sq) ? 64'd0 : one_g;
    if (mode_q == MODE_BW_HP && d2 == 0) return 64'd0;
    if (d0sq == 0) begin
      sat = 1'b1;
      ratio = 64'hFFFF_FFFF;
    end else begin
      ratio = (d2 << 16) / d0sq;
      if (ratio > 64'hFFFF_FFFF) begin
        ratio = 64'hFFFF_FFFF;
        sat = 1'b1;
      end
    end
    pw = 64'h1_0000;
    for (int k = 0; k < order_q; k++) begin
      if (sat) break;
      pw = (pw * ratio) >> 16;
      if (pw > 64'hFFFF_FFFF) begin
        sat = 1'b1;
        pw = 64'hFFFF_FFFF;
      end
    end
    if (sat && order_q == 0) sat = 1'b0;
    if (sat) return (mode_q == MODE_BW_LP) ? 64'd0 : one_g;
    if (mode_q == MODE_BW_LP) return (one_g << 16) / (64'h1_0000 + pw);
    return (pw << GAIN_FRACTION_BITS) / (64'h1_0000 + pw);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] scale_part(logic [SAMPLE_WIDTH-1:0] x,
                                                         logic [63:0] g);
    logic [63:0] mag, prod;
    logic        neg;
    neg  = x[SAMPLE_WIDTH-1];
    mag  = neg ? 64'(-x) : 64'(x);
    if (neg && mag == 0) mag = 64'd1 << (SAMPLE_WIDTH - 1);
    mag  = neg ? (64'd1 << SAMPLE_WIDTH) - 64'(x) : 64'(x);
    prod = (mag >> GAIN_FRACTION_BITS) * g
         + (((mag & ((64'd1 << GAIN_FRACTION_BITS) - 1)) * g) >> GAIN_FRACTION_BITS);
    if (neg) prod = -prod;
    return prod[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic out_item_t filter_bin(in_item_t b);
    logic [63:0] cx, cy, du, dv, g;
    out_item_t   o;
    cx = ((cols_q > MAX_DIMENSION) ? 64'(MAX_DIMENSION) : 64'(cols_q)) >> 1;
    cy = ((rows_q > MAX_DIMENSION) ? 64'(MAX_DIMENSION) : 64'(rows_q)) >> 1;
    du = (64'(b.bin_column) >= cx) ? 64'(b.bin_column) - cx : cx - 64'(b.bin_column);
    dv = (64'(b.bin_row) >= cy) ? 64'(b.bin_row) - cy : cy - 64'(b.bin_row);
    g  = radial_gain(du * du + dv * dv);
    o.out_real = scale_part(b.bin_real, g);
    o.out_imag = scale_part(b.bin_imag, g);
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_bin;
    int        errs;
    errs = 0;
    if (rst) begin
      mode_q   <= MODE_BW_LP;
      cutoff_q <= CUTOFF_RESET;
      order_q  <= ORDER_RESET;
      cols_q   <= FRAME_RESET;
      rows_q   <= FRAME_RESET;
      scaled_bins.delete();
      fail_count   <= 0;
      results_seen <= 0;
      pending      <= 0;
    end else begin
      if (write_enable) begin
        case (register_index)
          REG_FILTER_MODE:   mode_q   <= mode_t'(write_data[MODE_W-1:0]);
          REG_CUTOFF_RADIUS: cutoff_q <= write_data[CUTOFF_W-1:0];
          REG_FILTER_ORDER:  order_q  <= write_data[ORDER_W-1:0];
          REG_FRAME_COLUMNS: cols_q   <= write_data[FRAME_W-1:0];
          REG_FRAME_ROWS:    rows_q   <= write_data[FRAME_W-1:0];
          default: ;
        endcase
      end
      if (bin_valid && bin_ready) scaled_bins.push_back(filter_bin(bin));
      if (result_valid && result_ready) begin
        results_seen <= results_seen + 1;
        if (scaled_bins.size() == 0) begin
          $error("unexpected result %h", result);
          fail_count <= fail_count + 1;
        end else begin
          exp_bin = scaled_bins.pop_front();
          if (result.out_real !== exp_bin.out_real) begin
            $error("out_real expected %h actual %h", exp_bin.out_real, result.out_real);
            errs++;
          end
          if (result.out_imag !== exp_bin.out_imag) begin
            $error("out_imag expected %h actual %h", exp_bin.out_imag, result.out_imag);
            errs++;
          end
          if (errs != 0) fail_count <= fail_count + errs;
        end
      end
      pending <= scaled_bins.size();
    end
  end

endmodule

### tb/sv/tb_frequency_domain_mask_filter.sv
// tb_frequency_domain_mask_filter: stimulus and verdict for the mask filter
// drives bins, register phases and result stalls; depends on fdmf_pkg, fdmf_checker
`timescale 1ns / 1ps

module tb_frequency_domain_mask_filter;
  import fdmf_pkg::*;

  localparam int LATENCY = 184;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   bin_valid = 1'b0;
  logic                   bin_ready;
  in_item_t               bin = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  out_item_t              result;
  logic                   write_enable = 1'b0;
  logic [REG_INDEX_W-1:0] register_index = '0;
  logic [CFG_DATA_W-1:0]  write_data = '0;
  int                     fail_count, pending, results_seen;
  bit                     calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frequency_domain_mask_filter DUT (.*);

  fdmf_checker checker_i (.*);

  always @(posedge clk)
    result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);

  task automatic write_reg(logic [REG_INDEX_W-1:0] idx, int value);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= CFG_DATA_W'(value);
    @(posedge clk);
    write_enable   <= 1'b0;
  endtask

  task automatic send_bin(logic [31:0] re, logic [31:0] im, logic [9:0] row, logic [9:0] col);
    while (!calm && $urandom_range(99) < 14) begin
      bin_valid <= 1'b0;
      @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin <= '{re, im, row, col};
    do @(posedge clk); while (!bin_ready);
  endtask

  task automatic drain;
    bin_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_bins(int count, int cols, int rows, int d0);
    int cy, cx, r, c;
    cx = (cols > 1024 ? 1024 : cols) / 2;
    cy = (rows > 1024 ? 1024 : rows) / 2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        r = $urandom_range(1023);
        c = $urandom_range(1023);
      end else begin
        r = cy + int'($urandom_range(4 * d0 + 4)) - 2 * d0 - 2;
        c = cx + int'($urandom_range(4 * d0 + 4)) - 2 * d0 - 2;
        if (r < 0) r = 0;
        if (c < 0) c = 0;
        if (r > 1023) r = 1023;
        if (c > 1023) c = 1023;
      end
      send_bin(rand_sample(), rand_sample(), 10'(r), 10'(c));
    end
  endtask

  initial begin
    int mode, d0, ord, cols, rows;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: centre, edges, extreme samples
    send_bin(32'h8000_0000, 32'h7FFF_FFFF, 10'd512, 10'd512);
    send_bin(32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'd512, 10'd519);
    send_bin(32'h0000_0000, 32'h8000_0000, 10'd1023, 10'd1023);
    send_bin(32'hFFFF_FFFF, 32'h0001_0000, 10'd0, 10'd0);
    drain();

    for (int m = MODE_IDEAL_LP; m <= MODE_BW_HP; m++) begin
      write_reg(REG_FILTER_MODE, m);
      write_reg(REG_CUTOFF_RADIUS, 5);
      write_reg(REG_FILTER_ORDER, 2);
      write_reg(REG_FRAME_COLUMNS, 16);
      write_reg(REG_FRAME_ROWS, 2047);
      send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd512, 10'd8);
      send_bin(32'h1234_5678, 32'hEDCB_A988, 10'd512, 10'd13);
      send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd509, 10'd4);
      drain();
    end
    // zero cutoff, order zero, odd and tiny frames, large order
    write_reg(REG_CUTOFF_RADIUS, 0);
    write_reg(REG_FRAME_COLUMNS, 3);
    write_reg(REG_FRAME_ROWS, 2);
    send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd1, 10'd1);
    send_bin(32'h0000_ABCD, 32'hFFFF_0000, 10'd0, 10'd3);
    drain();
    write_reg(REG_CUTOFF_RADIUS, 511);
    write_reg(REG_FILTER_ORDER, 0);
    send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd700, 10'd600);
    drain();
    write_reg(REG_FILTER_ORDER, 127);
    write_reg(REG_FILTER_MODE, MODE_BW_LP);
    send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd300, 10'd301);
    send_bin(32'h7FFF_FFFF, 32'h8000_0000, 10'd1023, 10'd1023);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      mode = $urandom_range(3);
      d0   = (ph % 4 == 0) ? 1 : (ph % 4 == 1) ? 500 : $urandom_range(1, 60);
      ord  = (ph == 5) ? 127 : (ph == 6) ? 0 : $urandom_range(1, 12);
      cols = (ph == 7) ? 2 : (ph == 8) ? 1535 : 2 * $urandom_range(1, 512);
      rows = (ph == 9) ? 2 : (ph == 10) ? 2047 : 2 * $urandom_range(1, 512);
      calm = (ph == 3);
      write_reg(REG_FILTER_MODE, mode);
      write_reg(REG_CUTOFF_RADIUS, d0);
      write_reg(REG_FILTER_ORDER, ord);
      write_reg(REG_FRAME_COLUMNS, cols);
      write_reg(REG_FRAME_ROWS, rows);
      random_bins(52, cols, rows, d0 > 100 ? 100 : d0);
      drain();
    end
    calm = 1'b0;

    $display("covered all filter modes, cutoffs 0..511, orders 0..127 and frame extremes");
    $display("%0d results checked", results_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
